>>> hdl/eap_pkg.sv
// shared types, constants and fixed-point helpers for the eased animation progress block
package eap_pkg;

  localparam int OW = 20;
  localparam int PW = 2 * OW;
  localparam int RW = 25;
  localparam int AW = 22;

  localparam logic [0:0] OP_START  = 1'b0;
  localparam logic [0:0] OP_SAMPLE = 1'b1;

  localparam logic [0:0] CFG_ANIM_ENABLE = 1'b0;
  localparam logic [0:0] CFG_SPEED       = 1'b1;

  localparam logic [2:0] MODE_OUT_CUBIC = 3'd1;
  localparam logic [2:0] MODE_OUT_QUART = 3'd2;
  localparam logic [2:0] MODE_BEZ_A     = 3'd3;
  localparam logic [2:0] MODE_BEZ_B     = 3'd4;
  localparam logic [2:0] MODE_BEZ_C     = 3'd5;
  localparam logic [2:0] MODE_BEZ_D     = 3'd6;

  localparam logic [17:0] ONE_Q16 = 18'd65536;
  localparam logic [14:0] PROG_ONE = 15'd16384;
  localparam logic [14:0] PROG_MAX = 15'd32767;

  typedef logic signed [OW-1:0] coef_t;

  // x1, y1, x2, y2 of each curve in q16
  localparam coef_t CURVE [4][4] = '{
    '{20'sd3277,  20'sd45875,  20'sd6554,  20'sd65536},
    '{20'sd19661, 20'sd0,      20'sd52429, 20'sd9830},
    '{20'sd24904, 20'sd79299,  20'sd14418, 20'sd65536},
    '{20'sd27525, 20'sd109445, 20'sd13763, 20'sd58982}
  };

  typedef enum logic [4:0] {
    S_IDLE,
    S_START_DIV,
    S_T_DIV,
    S_EASE_SQ,
    S_EASE_P,
    S_UU,
    S_US,
    S_SS,
    S_X1,
    S_X2,
    S_X3,
    S_X4,
    S_X5,
    S_D1,
    S_D2,
    S_D3,
    S_NEWT_DIV,
    S_DONE
  } state_t;

  // q16 product rounded half away from zero
  function automatic logic signed [RW-1:0] q16_round(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] a;
    a = p[PW-1] ? -p : p;
    a = (a + PW'(32768)) >>> 16;
    return p[PW-1] ? -RW'(a) : RW'(a);
  endfunction

endpackage

>>> hdl/eap_mul.sv
// registered signed multiplier shared by all easing arithmetic
module eap_mul (
  input  logic                              clk,
  input  logic signed [eap_pkg::OW-1:0]     a,
  input  logic signed [eap_pkg::OW-1:0]     b,
  output logic signed [eap_pkg::PW-1:0]     p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> hdl/eap_div.sv
// restoring unsigned divider, one quotient bit per cycle
module eap_div #(
  parameter int NW = 38,
  parameter int DW = 22
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dv;
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW:0]   rem_sub;

  assign rem_sh  = {rem, quo[NW-1]};
  assign ge      = rem_sh >= {1'b0, dv};
  assign rem_sub = rem_sh - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end else if (start) begin
      rem <= '0;
      quo <= num;
      dv  <= den;
    end
  end

endmodule

>>> hdl/eased_animation_progress.sv
// Eased animation progress. A start transfer (op 0) scales nominal_ms by the speed register
// with one division; a disabled start or a sample at or past the end goes straight to the
// result. A sample forms t = elapsed/duration with the same divider, then out-cubic or
// out-quart adds a square and a product on the multiplier. Bezier modes add up to
// NEWTON_STEPS Newton steps, each a pass of multiplies and, unless it converges, one
// division, then the final curve, all on one shared multiplier and one shared divider.
// NW is the larger of 38 and DURATION_BITS+16. One item is processed at a time; the result
// sits in an output register and the next item may be taken while it waits.
module eased_animation_progress #(
  parameter int TIME_BITS     = 40,
  parameter int DURATION_BITS = 20,
  parameter int NEWTON_STEPS  = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [0:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [0:0]               op,
  input  logic [TIME_BITS-1:0]     now_ms,
  input  logic [15:0]              nominal_ms,
  input  logic [2:0]               ease_mode,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [14:0]              progress,
  output logic                     is_active,
  output logic [DURATION_BITS-1:0] scaled_duration
);

  localparam int NW = (DURATION_BITS + 16 > 38) ? DURATION_BITS + 16 : 38;
  localparam int DW = (DURATION_BITS > eap_pkg::AW) ? DURATION_BITS : eap_pkg::AW;
  localparam int SW = NW + 2;
  localparam int IW = $clog2(NEWTON_STEPS + 1);
  localparam int XW = (TIME_BITS > DURATION_BITS) ? TIME_BITS : DURATION_BITS;
  localparam int OW = eap_pkg::OW;
  localparam int AW = eap_pkg::AW;
  localparam int RW = eap_pkg::RW;
  localparam int PW = eap_pkg::PW;

  eap_pkg::state_t state, state_next;
  logic ph;

  logic                     anim_enable;
  logic [15:0]              speed_q8_8;
  logic [TIME_BITS-1:0]     start_time;
  logic [DURATION_BITS-1:0] duration;
  logic [2:0]               mode;
  logic                     running;

  logic [16:0]              t;
  logic signed [17:0]       s;
  logic signed [OW-1:0]     uu, us, ss, tmp, sq;
  logic signed [AW-1:0]     acc, x;
  logic [IW-1:0]            iter;
  logic                     fin;
  logic                     err_neg, dx_neg;
  logic [14:0]              res_prog;
  logic [NW-1:0]            dnum;
  logic [DW-1:0]            dden;

  logic signed [OW-1:0]     mul_a, mul_b;
  logic signed [PW-1:0]     mul_p;
  logic signed [RW-1:0]     qr;
  logic                     div_start, div_done;
  logic [NW-1:0]            quo;

  logic [15:0]              sp;
  logic [TIME_BITS-1:0]     diff_raw, diff;
  logic                     samp_end;
  logic signed [17:0]       u;
  logic [16:0]              inv;
  logic [1:0]               cidx;
  logic signed [AW-1:0]     qa, dx_full, err;
  logic                     newt_stop;
  logic signed [SW-1:0]     s_new;
  logic signed [PW:0]       ease_w;
  logic [DURATION_BITS-1:0] d_clamp;

  function automatic logic [14:0] to_prog(input logic signed [RW-1:0] v);
    logic [RW-1:0] w;
    w = RW'(v + RW'(2)) >> 2;
    if (v[RW-1]) return '0;
    if (w > RW'(eap_pkg::PROG_MAX)) return eap_pkg::PROG_MAX;
    return w[14:0];
  endfunction

  eap_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  eap_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (dnum),
    .den   (dden),
    .done  (div_done),
    .quo   (quo)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == eap_pkg::S_IDLE);

  assign sp       = (speed_q8_8 <= 16'd2) ? 16'd256 : speed_q8_8;
  assign diff_raw = now_ms - start_time;
  assign diff     = diff_raw[TIME_BITS-1] ? '0 : diff_raw;
  assign samp_end = XW'(diff) >= XW'(duration);
  assign u        = $signed(eap_pkg::ONE_Q16) - s;
  assign inv      = 17'(eap_pkg::ONE_Q16 - 18'(t));
  assign cidx     = 2'(mode - eap_pkg::MODE_BEZ_A);
  assign qr       = eap_pkg::q16_round(mul_p);
  assign qa       = AW'(qr);
  assign dx_full  = acc + (qa <<< 1) + qa;
  assign err      = x - AW'($signed({1'b0, t}));
  assign newt_stop = (dx_full == '0) || (err == '0);
  assign s_new    = (err_neg != dx_neg) ? SW'(s) + $signed(SW'(quo))
                                        : SW'(s) - $signed(SW'(quo));
  assign ease_w   = $signed((PW + 1)'(64'h1_0000_8000)) - (PW + 1)'(mul_p);
  assign d_clamp  = (quo == '0) ? DURATION_BITS'(1) :
                    (quo > NW'({DURATION_BITS{1'b1}})) ? {DURATION_BITS{1'b1}} :
                    quo[DURATION_BITS-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      eap_pkg::S_IDLE: begin
        if (in_valid) begin
          if (op == eap_pkg::OP_START) state_next = anim_enable ? eap_pkg::S_START_DIV
                                                                 : eap_pkg::S_DONE;
          else state_next = samp_end ? eap_pkg::S_DONE : eap_pkg::S_T_DIV;
        end
      end
      eap_pkg::S_START_DIV: if (ph && div_done) state_next = eap_pkg::S_DONE;
      eap_pkg::S_T_DIV: begin
        if (ph && div_done) begin
          case (mode) inside
            eap_pkg::MODE_OUT_CUBIC, eap_pkg::MODE_OUT_QUART: state_next = eap_pkg::S_EASE_SQ;
            [eap_pkg::MODE_BEZ_A:eap_pkg::MODE_BEZ_D]:
              state_next = (quo == '0) ? eap_pkg::S_DONE : eap_pkg::S_UU;
            default: state_next = eap_pkg::S_DONE;
          endcase
        end
      end
      eap_pkg::S_EASE_SQ: if (ph) state_next = eap_pkg::S_EASE_P;
      eap_pkg::S_EASE_P:  if (ph) state_next = eap_pkg::S_DONE;
      eap_pkg::S_UU:      if (ph) state_next = eap_pkg::S_US;
      eap_pkg::S_US:      if (ph) state_next = eap_pkg::S_SS;
      eap_pkg::S_SS:      if (ph) state_next = eap_pkg::S_X1;
      eap_pkg::S_X1:      if (ph) state_next = eap_pkg::S_X2;
      eap_pkg::S_X2:      if (ph) state_next = eap_pkg::S_X3;
      eap_pkg::S_X3:      if (ph) state_next = eap_pkg::S_X4;
      eap_pkg::S_X4:      if (ph) state_next = eap_pkg::S_X5;
      eap_pkg::S_X5:      if (ph) state_next = fin ? eap_pkg::S_DONE : eap_pkg::S_D1;
      eap_pkg::S_D1:      if (ph) state_next = eap_pkg::S_D2;
      eap_pkg::S_D2:      if (ph) state_next = eap_pkg::S_D3;
      eap_pkg::S_D3:      if (ph) state_next = newt_stop ? eap_pkg::S_UU : eap_pkg::S_NEWT_DIV;
      eap_pkg::S_NEWT_DIV: if (ph && div_done) state_next = eap_pkg::S_UU;
      eap_pkg::S_DONE:    if (!out_valid || out_ready) state_next = eap_pkg::S_IDLE;
      default:            state_next = eap_pkg::S_IDLE;
    endcase
  end

  // operand selection for the shared units
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state)
      eap_pkg::S_START_DIV, eap_pkg::S_T_DIV, eap_pkg::S_NEWT_DIV: div_start = !ph;
      eap_pkg::S_EASE_SQ: begin
        mul_a = OW'(inv);
        mul_b = OW'(inv);
      end
      eap_pkg::S_EASE_P: begin
        mul_a = sq;
        mul_b = (mode == eap_pkg::MODE_OUT_CUBIC) ? OW'(inv) : sq;
      end
      eap_pkg::S_UU: begin
        mul_a = OW'(u);
        mul_b = OW'(u);
      end
      eap_pkg::S_US: begin
        mul_a = OW'(u);
        mul_b = OW'(s);
      end
      eap_pkg::S_SS, eap_pkg::S_X5: begin
        mul_a = (state == eap_pkg::S_SS) ? OW'(s) : ss;
        mul_b = OW'(s);
      end
      eap_pkg::S_X1: begin
        mul_a = uu;
        mul_b = OW'(s);
      end
      eap_pkg::S_X2: begin
        mul_a = tmp;
        mul_b = fin ? eap_pkg::CURVE[cidx][1] : eap_pkg::CURVE[cidx][0];
      end
      eap_pkg::S_X3: begin
        mul_a = us;
        mul_b = OW'(s);
      end
      eap_pkg::S_X4: begin
        mul_a = tmp;
        mul_b = fin ? eap_pkg::CURVE[cidx][3] : eap_pkg::CURVE[cidx][2];
      end
      eap_pkg::S_D1: begin
        mul_a = uu;
        mul_b = eap_pkg::CURVE[cidx][0];
      end
      eap_pkg::S_D2: begin
        mul_a = us;
        mul_b = eap_pkg::CURVE[cidx][2] - eap_pkg::CURVE[cidx][0];
      end
      eap_pkg::S_D3: begin
        mul_a = ss;
        mul_b = OW'($signed(eap_pkg::ONE_Q16)) - eap_pkg::CURVE[cidx][2];
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= eap_pkg::S_IDLE;
      ph          <= 1'b0;
      out_valid   <= 1'b0;
      anim_enable <= 1'b1;
      speed_q8_8  <= 16'd256;
      start_time  <= '0;
      duration    <= '0;
      mode        <= '0;
      running     <= 1'b0;
    end else begin
      state <= state_next;
      ph    <= (state_next == state);
      if (cfg_valid) begin
        unique case (cfg_index)
          eap_pkg::CFG_ANIM_ENABLE: anim_enable <= cfg_data[0];
          eap_pkg::CFG_SPEED:       speed_q8_8  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == eap_pkg::S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        eap_pkg::S_IDLE: begin
          if (in_valid) begin
            if (op == eap_pkg::OP_START) begin
              start_time <= now_ms;
              mode       <= ease_mode;
              duration   <= '0;
              running    <= 1'b0;
            end else if (samp_end) begin
              running <= 1'b0;
            end
          end
        end
        eap_pkg::S_START_DIV: begin
          if (ph && div_done) begin
            duration <= d_clamp;
            running  <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      eap_pkg::S_IDLE: begin
        if (in_valid) begin
          if (op == eap_pkg::OP_START) begin
            res_prog <= '0;
            dnum     <= NW'({nominal_ms, 9'b0}) + NW'(sp);
            dden     <= DW'({sp, 1'b0});
          end else begin
            res_prog <= eap_pkg::PROG_ONE;
            dnum     <= NW'({diff[DURATION_BITS-1:0], 16'b0});
            dden     <= DW'(duration);
          end
        end
      end
      eap_pkg::S_T_DIV: begin
        if (ph && div_done) begin
          t        <= quo[16:0];
          s        <= 18'(quo[16:0]);
          iter     <= '0;
          fin      <= 1'b0;
          res_prog <= to_prog(RW'(quo[16:0]));
        end
      end
      eap_pkg::S_EASE_SQ: if (ph) sq <= OW'(qr);
      eap_pkg::S_EASE_P:  if (ph) res_prog <= to_prog(RW'(ease_w >>> 16));
      eap_pkg::S_UU:      if (ph) uu <= OW'(qr);
      eap_pkg::S_US:      if (ph) us <= OW'(qr);
      eap_pkg::S_SS:      if (ph) ss <= OW'(qr);
      eap_pkg::S_X1, eap_pkg::S_X3: if (ph) tmp <= OW'(qr);
      eap_pkg::S_X2, eap_pkg::S_D1: if (ph) acc <= (qa <<< 1) + qa;
      eap_pkg::S_X4:      if (ph) acc <= acc + (qa <<< 1) + qa;
      eap_pkg::S_X5: begin
        if (ph) begin
          x        <= acc + qa;
          res_prog <= to_prog(RW'(acc + qa));
        end
      end
      eap_pkg::S_D2:      if (ph) acc <= acc + (qa <<< 2) + (qa <<< 1);
      eap_pkg::S_D3: begin
        if (ph) begin
          if (newt_stop) fin <= 1'b1;
          err_neg <= err[AW-1];
          dx_neg  <= dx_full[AW-1];
          dnum    <= NW'({(err[AW-1] ? -err : err), 16'b0});
          dden    <= DW'(dx_full[AW-1] ? -dx_full : dx_full);
        end
      end
      eap_pkg::S_NEWT_DIV: begin
        if (ph && div_done) begin
          if (s_new < 0) s <= '0;
          else if (s_new > SW'($signed(eap_pkg::ONE_Q16))) s <= $signed(eap_pkg::ONE_Q16);
          else s <= 18'(s_new);
          iter <= iter + 1'b1;
          if (iter == IW'(NEWTON_STEPS - 1)) fin <= 1'b1;
        end
      end
      eap_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          progress        <= res_prog;
          is_active       <= running;
          scaled_duration <= duration;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> bench/tb_eased_animation_progress.sv
// self-checking testbench for eased_animation_progress with directed table and random traffic
`timescale 1ns / 1ps

module tb_eased_animation_progress;

  localparam int TB = 40;
  localparam int DB = 20;
  localparam logic [2:0] MODE_LINEAR = 3'd0;
  localparam logic [2:0] MODE_LINEAR_ALT = 3'd7;
  localparam int WATCH_LIMIT = 5000;
  localparam int LONG_HOLD = 300;
  localparam longint Q1 = 65536;

  typedef struct packed {
    logic [14:0] prog;
    logic        act;
    logic [19:0] dur;
  } outcome_t;

  typedef struct {
    logic [0:0]  op;
    logic [39:0] now;
    logic [15:0] base;
    logic [2:0]  mode;
    bit          typed;
    outcome_t    want;
  } row_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [0:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_ready;
  logic [0:0] op;
  logic [TB-1:0] now_ms;
  logic [15:0] nominal_ms;
  logic [2:0] ease_mode;
  logic out_valid, out_ready;
  logic [14:0] progress;
  logic is_active;
  logic [DB-1:0] scaled_duration;

  eased_animation_progress uut (.*);

  // predictor state
  logic [TB-1:0] anim_start;
  logic [DB-1:0] anim_dur;
  logic [2:0] anim_mode;
  logic anim_run;
  logic en_reg;
  logic [15:0] speed_reg;
  longint curve_coef [4][4] = '{
    '{3277, 45875, 6554, 65536},
    '{19661, 0, 52429, 9830},
    '{24904, 79299, 14418, 65536},
    '{27525, 109445, 13763, 58982}
  };

  outcome_t pending_results[$];
  int errors, n_starts, n_samples, n_done, idle_cycles;
  int burst_left;
  bit hold_req;
  int stall_style;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint qmul_round(longint a, longint b);
    longint p;
    p = a * b;
    if (p >= 0) return (p + 32768) / 65536;
    return -((-p + 32768) / 65536);
  endfunction

  function automatic longint curve_poly(longint s, longint c1, longint c2);
    longint u, uu, us, ss;
    u = Q1 - s;
    uu = qmul_round(u, u);
    us = qmul_round(u, s);
    ss = qmul_round(s, s);
    return 3 * qmul_round(qmul_round(uu, s), c1) + 3 * qmul_round(qmul_round(us, s), c2)
           + qmul_round(ss, s);
  endfunction

  function automatic longint curve_solve(int k, longint t);
    longint s, u, uu, us, ss, x, dx, err;
    s = t;
    if (t <= 0) return 0;
    if (t >= Q1) return Q1;
    for (int i = 0; i < 8; i++) begin
      u = Q1 - s;
      uu = qmul_round(u, u);
      us = qmul_round(u, s);
      ss = qmul_round(s, s);
      x = curve_poly(s, curve_coef[k][0], curve_coef[k][2]);
      dx = 3 * qmul_round(uu, curve_coef[k][0])
         + 6 * qmul_round(us, curve_coef[k][2] - curve_coef[k][0])
         + 3 * qmul_round(ss, Q1 - curve_coef[k][2]);
      if (dx == 0) break;
      err = x - t;
      if (err == 0) break;
      s = s - (err * Q1) / dx;
      if (s < 0) s = 0;
      if (s > Q1) s = Q1;
    end
    return curve_poly(s, curve_coef[k][1], curve_coef[k][3]);
  endfunction

  function automatic logic [14:0] eased_q14(logic [2:0] m, longint t);
    longint inv, sq, v;
    inv = Q1 - t;
    sq = (inv * inv + 32768) >>> 16;
    case (m)
      eap_pkg::MODE_OUT_CUBIC: v = ((64'sd1 <<< 32) - sq * inv + 32768) >>> 16;
      eap_pkg::MODE_OUT_QUART: v = ((64'sd1 <<< 32) - sq * sq + 32768) >>> 16;
      eap_pkg::MODE_BEZ_A, eap_pkg::MODE_BEZ_B, eap_pkg::MODE_BEZ_C, eap_pkg::MODE_BEZ_D:
        v = curve_solve(m - eap_pkg::MODE_BEZ_A, t);
      default: v = t;
    endcase
    if (v < 0) v = 0;
    v = (v + 2) >>> 2;
    if (v > 32767) v = 32767;
    return v[14:0];
  endfunction

  function automatic outcome_t progress_step(logic [0:0] o, logic [39:0] now, logic [15:0] base,
                                             logic [2:0] m);
    outcome_t r;
    longint sp, d;
    logic [39:0] diff;
    r.prog = '0;
    if (o == eap_pkg::OP_START) begin
      d = 0;
      if (en_reg) begin
        sp = (speed_reg <= 2) ? 256 : longint'(speed_reg);
        d = (longint'(base) * 512 + sp) / (2 * sp);
        if (d < 1) d = 1;
        if (d > 20'hFFFFF) d = 20'hFFFFF;
      end
      anim_start = now;
      anim_dur = d[19:0];
      anim_mode = m;
      anim_run = d > 0;
    end else if (anim_dur == 0) begin
      anim_run = 0;
      r.prog = eap_pkg::PROG_ONE;
    end else begin
      diff = now - anim_start;
      if (diff[39]) diff = '0;
      if (diff >= anim_dur) begin
        anim_run = 0;
        r.prog = eap_pkg::PROG_ONE;
      end else begin
        r.prog = eased_q14(anim_mode, (longint'(diff) <<< 16) / longint'(anim_dur));
      end
    end
    r.act = anim_run;
    r.dur = anim_dur;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, queue depth", 1, 0);
      end else begin
        outcome_t w;
        w = pending_results.pop_front();
        if (progress !== w.prog) report_mismatch("progress", progress, w.prog);
        if (is_active !== w.act) report_mismatch("is_active", is_active, w.act);
        if (scaled_duration !== w.dur) report_mismatch("scaled_duration", scaled_duration, w.dur);
        n_done++;
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("tb_eased_animation_progress failed");
      $finish;
    end
  end

  // receiver stall pattern
  initial begin
    int left;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 0;
        out_ready <= 1'b1;
      end else begin
        if (left == 0) begin
          stall_style = $urandom_range(0, 3);
          left = $urandom_range(50, 300);
        end
        left--;
        case (stall_style)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 1) != 0);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == eap_pkg::CFG_ANIM_ENABLE) en_reg = val[0];
    else speed_reg = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sends one item; typed expectations replace the predicted one
  task automatic send_item(logic [0:0] o, logic [39:0] now, logic [15:0] base, logic [2:0] m,
                           bit typed = 0, outcome_t want = '0);
    outcome_t p;
    in_valid <= 1'b1;
    op <= o;
    now_ms <= now;
    nominal_ms <= base;
    ease_mode <= m;
    do @(posedge clk); while (!in_ready);
    p = progress_step(o, now, base, m);
    pending_results.push_back(typed ? want : p);
    if (o == eap_pkg::OP_START) n_starts++;
    else n_samples++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic drain();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    wait (pending_results.size() == 0);
    @(posedge clk);
  endtask

  task automatic random_traffic(int count);
    logic [39:0] st, el;
    logic [15:0] b;
    int k, nsamp;
    k = 0;
    while (k < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'($urandom_range(0, 1)), 40'({$urandom, $urandom}), 16'($urandom),
                  3'($urandom));
        k++;
      end else begin
        st = 40'({$urandom, $urandom});
        b = 16'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 20) : $urandom);
        send_item(eap_pkg::OP_START, st, b, 3'($urandom));
        k++;
        nsamp = $urandom_range(1, 6);
        for (int j = 0; j < nsamp; j++) begin
          el = 40'($urandom_range(0, anim_dur + anim_dur / 4 + 2));
          if ($urandom_range(0, 15) == 0) el = -40'($urandom_range(1, 1000));
          send_item(eap_pkg::OP_SAMPLE, st + el, 16'($urandom), 3'($urandom));
          k++;
        end
      end
    end
  endtask

  row_t dir_rows[] = '{
    '{eap_pkg::OP_SAMPLE, 40'd0, 16'd0, MODE_LINEAR, 1,
      '{15'd16384, 1'b0, 20'd0}},
    '{eap_pkg::OP_START, 40'd1000, 16'd0, MODE_LINEAR, 1,
      '{15'd0, 1'b1, 20'd1}},
    '{eap_pkg::OP_SAMPLE, 40'd1001, 16'hFFFF, MODE_LINEAR, 1,
      '{15'd16384, 1'b0, 20'd1}},
    '{eap_pkg::OP_SAMPLE, 40'd5000, 16'd0, MODE_LINEAR, 1,
      '{15'd16384, 1'b0, 20'd1}},
    '{eap_pkg::OP_START, 40'd0, 16'd65535, eap_pkg::MODE_OUT_CUBIC, 1,
      '{15'd0, 1'b1, 20'd65535}},
    '{eap_pkg::OP_SAMPLE, 40'd100, 16'd0, MODE_LINEAR, 0, '0},
    '{eap_pkg::OP_SAMPLE, 40'd65534, 16'd0, MODE_LINEAR, 0, '0},
    '{eap_pkg::OP_START, 40'd5000, 16'd1000, MODE_LINEAR, 1,
      '{15'd0, 1'b1, 20'd1000}},
    '{eap_pkg::OP_SAMPLE, 40'd4000, 16'd0, MODE_LINEAR, 1,
      '{15'd0, 1'b1, 20'd1000}},
    '{eap_pkg::OP_SAMPLE, 40'd5500, 16'd0, MODE_LINEAR, 1,
      '{15'd8192, 1'b1, 20'd1000}},
    '{eap_pkg::OP_START, 40'hFF_FFFF_FF00, 16'd1000, eap_pkg::MODE_BEZ_A, 1,
      '{15'd0, 1'b1, 20'd1000}},
    '{eap_pkg::OP_SAMPLE, 40'h100, 16'd0, MODE_LINEAR, 0, '0},
    '{eap_pkg::OP_START, 40'd0, 16'd300, eap_pkg::MODE_OUT_QUART, 0, '0},
    '{eap_pkg::OP_SAMPLE, 40'd150, 16'd0, MODE_LINEAR, 0, '0},
    '{eap_pkg::OP_START, 40'd0, 16'd300, eap_pkg::MODE_BEZ_B, 0, '0},
    '{eap_pkg::OP_SAMPLE, 40'd100, 16'd0, MODE_LINEAR, 0, '0},
    '{eap_pkg::OP_START, 40'd0, 16'd300, eap_pkg::MODE_BEZ_C, 0, '0},
    '{eap_pkg::OP_SAMPLE, 40'd200, 16'd0, MODE_LINEAR, 0, '0},
    '{eap_pkg::OP_START, 40'd0, 16'd300, eap_pkg::MODE_BEZ_D, 0, '0},
    '{eap_pkg::OP_SAMPLE, 40'd150, 16'd0, MODE_LINEAR, 0, '0},
    '{eap_pkg::OP_START, 40'd0, 16'd300, MODE_LINEAR_ALT, 0, '0},
    '{eap_pkg::OP_SAMPLE, 40'd75, 16'd0, MODE_LINEAR, 1,
      '{15'd4096, 1'b1, 20'd300}},
    '{eap_pkg::OP_SAMPLE, 40'hFF_FFFF_FFFF, 16'd0, MODE_LINEAR, 1,
      '{15'd0, 1'b1, 20'd300}}
  };

  // anim_enable and speed per phase: reset value, slow speeds, extremes, disabled
  logic [16:0] phase_cfg[] = '{
    {1'b1, 16'd256}, {1'b1, 16'd2}, {1'b1, 16'd0}, {1'b1, 16'd65535},
    {1'b1, 16'd3}, {1'b0, 16'd256}, {1'b1, 16'd128}, {1'b1, 16'd1000}
  };

  initial begin
    rst = 1'b1;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; op = '0; now_ms = '0; nominal_ms = '0; ease_mode = '0;
    out_ready = 1'b1;
    errors = 0; n_starts = 0; n_samples = 0; n_done = 0; idle_cycles = 0;
    burst_left = 0; hold_req = 0; stall_style = 0;
    anim_start = '0; anim_dur = '0; anim_mode = '0; anim_run = 0;
    en_reg = 1'b1; speed_reg = 16'd256;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].now, dir_rows[i].base, dir_rows[i].mode,
                dir_rows[i].typed, dir_rows[i].want);
    drain();

    foreach (phase_cfg[i]) begin
      write_reg(eap_pkg::CFG_ANIM_ENABLE, {15'd0, phase_cfg[i][16]});
      write_reg(eap_pkg::CFG_SPEED, phase_cfg[i][15:0]);
      if (i == 1) hold_req = 1;
      random_traffic(55);
      if (i == 3) drain();
      if (i == 6) hold_req = 1;
      random_traffic(55);
      drain();
    end
    write_reg(eap_pkg::CFG_SPEED, 16'($urandom));
    write_reg(eap_pkg::CFG_ANIM_ENABLE, 16'd1);
    random_traffic(30);
    drain();

    repeat (700) @(posedge clk);
    $display("covered %0d starts and %0d samples over %0d register settings",
             n_starts, n_samples, phase_cfg.size() + 2);
    $display("%0d results checked, %0d mismatches", n_done, errors);
    if (errors == 0)
      $display("tb_eased_animation_progress passed");
    else
      $display("tb_eased_animation_progress failed");
    $finish;
  end

endmodule

>>> filelist.f
hdl/eap_pkg.sv
hdl/eap_mul.sv
hdl/eap_div.sv
hdl/eased_animation_progress.sv
bench/tb_eased_animation_progress.sv
